// ----- rtl/edd_pkg.sv -----
// ----------------------------------------------------------------------------
// edd_pkg
// Shared types and constants of the error diffusion dither unit.
// ----------------------------------------------------------------------------
package edd_pkg;

  // default sizing
  localparam int unsigned MaxWidthDef = 1024;
  localparam int unsigned FracBitsDef = 4;

  // fixed field and register widths
  localparam int unsigned LevelW     = 8;
  localparam int unsigned ErrIntW    = 10;
  localparam int unsigned ChanNum    = 3;
  localparam int unsigned WidthRegW  = 11;
  localparam int unsigned HeightRegW = 13;
  localparam int unsigned RowCntW    = 12;
  localparam int unsigned CfgDataW   = 13;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned MaxHeight  = 4096;

  // register reset values
  localparam int unsigned WidthRst  = 640;
  localparam int unsigned HeightRst = 480;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegImageWidth  = 1'b0,
    RegImageHeight = 1'b1
  } cfg_reg_e;

  // input word: one rgb pixel
  typedef struct packed {
    logic [LevelW-1:0] red_in;
    logic [LevelW-1:0] green_in;
    logic [LevelW-1:0] blue_in;
  } pix_in_t;

  // output word: one dithered pixel
  typedef struct packed {
    logic red_bit;
    logic green_bit;
    logic blue_bit;
    logic frame_last;
  } pix_out_t;

endpackage

// ----- rtl/edd_if.sv -----
// ----------------------------------------------------------------------------
// edd_if
// Valid/ready stream interfaces for the input and output pixel words.
// ----------------------------------------------------------------------------
interface edd_pix_in_if;
  logic             valid;
  logic             ready;
  edd_pkg::pix_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface edd_pix_out_if;
  logic              valid;
  logic              ready;
  edd_pkg::pix_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/edd_chan.sv -----
// ----------------------------------------------------------------------------
// edd_chan
// One color channel: threshold of the accumulated level and the weighted
// split of its quantization error into right, below-left, below and
// below-right parts.
// ----------------------------------------------------------------------------
module edd_chan #(
  parameter int unsigned FRACTION_BITS = edd_pkg::FracBitsDef,
  localparam int unsigned EW = edd_pkg::ErrIntW + FRACTION_BITS
) (
  input  logic [edd_pkg::LevelW-1:0] level_i,
  input  logic signed [EW-1:0]       carry_i,      // error from the left
  input  logic signed [EW-1:0]       below_i,      // error from the row above
  input  logic                       use_below_i,
  input  logic signed [EW-1:0]       pend_left_i,  // partial below-left sum
  input  logic signed [EW-1:0]       pend_this_i,  // partial below sum
  output logic                       bit_o,
  output logic signed [EW-1:0]       down_left_o,  // finished below-left entry
  output logic signed [EW-1:0]       pend_left_o,  // next below-left partial
  output logic signed [EW-1:0]       pend_this_o,  // next below partial
  output logic signed [EW-1:0]       carry_o       // next error to the right
);

  localparam int unsigned AccW = EW + 2;
  localparam int unsigned SumW = AccW + 4;
  localparam int unsigned WShift = 4;

  localparam logic signed [AccW-1:0] HalfLvl = AccW'(128 * (2 ** FRACTION_BITS));
  localparam logic signed [AccW-1:0] FullLvl = AccW'(255 * (2 ** FRACTION_BITS));
  localparam logic signed [SumW-1:0] ErrMax  = SumW'((2 ** (EW - 1)) - 1);
  localparam logic signed [SumW-1:0] ErrMin  = SumW'(-(2 ** (EW - 1)));

  function automatic logic signed [EW-1:0] sat_err(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] r;
    r = v;
    if (v > ErrMax) r = ErrMax;
    else if (v < ErrMin) r = ErrMin;
    return EW'(r);
  endfunction

  logic signed [AccW-1:0] lvl;
  logic signed [AccW-1:0] acc;
  logic signed [AccW-1:0] err;
  logic signed [SumW-1:0] e_x;
  logic signed [SumW-1:0] w1, w3, w5, w7;

  // accumulated level
  always_comb begin
    lvl = AccW'({1'b0, level_i}) <<< FRACTION_BITS;
    acc = lvl + AccW'(carry_i) + (use_below_i ? AccW'(below_i) : '0);
  end

  // threshold at half level and quantization error
  assign bit_o = (acc >= HalfLvl);
  assign err   = acc - (bit_o ? FullLvl : '0);

  // weighted parts in sixteenths, floored by the arithmetic shift
  always_comb begin
    e_x = SumW'(err);
    w1  = e_x >>> WShift;
    w3  = ((e_x <<< 1) + e_x) >>> WShift;
    w5  = ((e_x <<< 2) + e_x) >>> WShift;
    w7  = ((e_x <<< 3) - e_x) >>> WShift;
  end

  // saturated stores
  assign down_left_o = sat_err(SumW'(pend_left_i) + w3);
  assign pend_left_o = sat_err(SumW'(pend_this_i) + w5);
  assign pend_this_o = sat_err(w1);
  assign carry_o     = sat_err(w7);

endmodule

// ----- rtl/error_diffusion_dither_unit.sv -----
// ----------------------------------------------------------------------------
// error_diffusion_dither_unit
// Floyd-Steinberg dither of an rgb pixel stream to one bit per channel.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock in raster order while the output is free, a
// rate set by the registered error carry from each pixel to its right neighbor
// in the channel datapath, and gives one dithered word per pixel, registered
// in the pixel stage and then the output register. The below errors of the
// previous row live in a MAX_WIDTH-deep single-port-write, single-port-read
// memory; a registered read is issued as the pixel is accepted, and writes of
// the current row are forwarded where they meet a read. The memory is never
// cleared: every entry that is used was written in the row before, so no
// clearing pass runs after reset. The user must write image width and height
// over the configuration port only while the unit is idle; the unit does not
// enforce this. Widths are taken in 2 to MAX_WIDTH and heights in 1 to 4096.
// ----------------------------------------------------------------------------
module error_diffusion_dither_unit #(
  parameter int unsigned MAX_WIDTH     = edd_pkg::MaxWidthDef,
  parameter int unsigned FRACTION_BITS = edd_pkg::FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [edd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [edd_pkg::CfgDataW-1:0] cfg_wdata_i,
  edd_pix_in_if.sink                   pix_i,
  edd_pix_out_if.source                pix_o
);

  localparam int unsigned EW  = edd_pkg::ErrIntW + FRACTION_BITS;
  localparam int unsigned MW  = edd_pkg::ChanNum * EW;
  localparam int unsigned AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW  = (AW + 1 > edd_pkg::WidthRegW) ? AW + 1 : edd_pkg::WidthRegW;
  localparam int unsigned HW  = edd_pkg::HeightRegW;
  localparam int unsigned RW  = edd_pkg::RowCntW;

  // configuration registers
  logic [edd_pkg::WidthRegW-1:0] width_q;
  logic [HW-1:0]                 height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= edd_pkg::WidthRegW'(edd_pkg::WidthRst);
      height_q <= HW'(edd_pkg::HeightRst);
    end else if (cfg_we_i) begin
      unique case (edd_pkg::cfg_reg_e'(cfg_idx_i))
        edd_pkg::RegImageWidth:  width_q  <= cfg_wdata_i[edd_pkg::WidthRegW-1:0];
        edd_pkg::RegImageHeight: height_q <= cfg_wdata_i[HW-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [CW-1:0] w_raw, w_eff, w_m1;
  logic [HW-1:0] h_eff, h_m1;

  always_comb begin
    w_raw = CW'(width_q);
    if (w_raw < CW'(2)) w_eff = CW'(2);
    else if (w_raw > CW'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
    else w_eff = w_raw;
    w_m1 = w_eff - CW'(1);
    if (height_q == '0) h_eff = HW'(1);
    else if (height_q > HW'(edd_pkg::MaxHeight)) h_eff = HW'(edd_pkg::MaxHeight);
    else h_eff = height_q;
    h_m1 = h_eff - HW'(1);
  end

  // handshake
  logic s1_v_q, out_v_q, s1_fire, in_fire;

  assign s1_fire     = s1_v_q && (!out_v_q || pix_o.ready);
  assign pix_i.ready = !s1_v_q || s1_fire;
  assign in_fire     = pix_i.valid && pix_i.ready;

  // raster position of the incoming pixel
  logic [AW-1:0] col_q, col_d, in_x;
  logic [RW-1:0] row_q, row_d;
  logic          in_last_col, in_last_row;

  always_comb begin
    in_last_col = (CW'(col_q) >= w_m1);
    in_last_row = (HW'(row_q) >= h_m1);
    in_x        = in_last_col ? w_m1[AW-1:0] : col_q;
    col_d       = in_last_col ? '0 : col_q + AW'(1);
    if (!in_last_col) row_d = row_q;
    else if (in_last_row) row_d = '0;
    else row_d = row_q + RW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // pixel stage
  edd_pkg::pix_in_t s1_pix_q;
  logic [AW-1:0]    s1_x_q;
  logic             s1_last_col_q, s1_last_row_q, s1_first_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (pix_i.ready) begin
      s1_v_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q       <= pix_i.data;
      s1_x_q         <= in_x;
      s1_last_col_q  <= in_last_col;
      s1_last_row_q  <= in_last_row;
      s1_first_row_q <= (row_q == '0);
    end
  end

  // row store write port: below-left entries, or the held end-of-row entry
  logic          tail_v_q;
  logic [AW-1:0] tail_addr_q;
  logic [MW-1:0] tail_q;
  logic          s1_wr, tail_ret, mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic [MW-1:0] down_left_all, pend_left_all, pend_this_all, carry_all;

  always_comb begin
    s1_wr     = s1_fire && (s1_x_q != '0);
    tail_ret  = tail_v_q && (!s1_v_q || (s1_fire && (s1_x_q == '0)));
    mem_we    = s1_wr || tail_ret;
    mem_waddr = s1_wr ? s1_x_q - AW'(1) : tail_addr_q;
    mem_wdata = s1_wr ? down_left_all : tail_q;
  end

  // row error memory
  logic [MW-1:0] row_mem_q [MAX_WIDTH];
  logic [MW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q <= row_mem_q[in_x];
    end
    if (mem_we) begin
      row_mem_q[mem_waddr] <= mem_wdata;
    end
  end

  // bypass of a write that meets the read in the same cycle
  logic          byp_v_q;
  logic [MW-1:0] byp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_v_q <= 1'b0;
    end else if (in_fire) begin
      byp_v_q <= mem_we && (mem_waddr == in_x);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byp_q <= mem_wdata;
    end
  end

  // below error with the newest value first
  logic [MW-1:0] below_all;

  always_comb begin
    if (tail_v_q && (tail_addr_q == s1_x_q)) below_all = tail_q;
    else if (byp_v_q) below_all = byp_q;
    else below_all = rd_q;
  end

  // per-channel datapath
  logic [MW-1:0]             rc_q, pl_q, pt_q;
  logic [edd_pkg::LevelW-1:0] lvl [edd_pkg::ChanNum];
  logic [edd_pkg::ChanNum-1:0] bits;

  assign lvl[0] = s1_pix_q.red_in;
  assign lvl[1] = s1_pix_q.green_in;
  assign lvl[2] = s1_pix_q.blue_in;

  for (genvar c = 0; c < edd_pkg::ChanNum; c++) begin : g_chan
    edd_chan #(
      .FRACTION_BITS(FRACTION_BITS)
    ) u_chan (
      .level_i    (lvl[c]),
      .carry_i    (rc_q[c*EW +: EW]),
      .below_i    (below_all[c*EW +: EW]),
      .use_below_i(!s1_first_row_q),
      .pend_left_i(pl_q[c*EW +: EW]),
      .pend_this_i(pt_q[c*EW +: EW]),
      .bit_o      (bits[c]),
      .down_left_o(down_left_all[c*EW +: EW]),
      .pend_left_o(pend_left_all[c*EW +: EW]),
      .pend_this_o(pend_this_all[c*EW +: EW]),
      .carry_o    (carry_all[c*EW +: EW])
    );
  end

  // carried errors, cleared at the end of each row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q <= '0;
      pl_q <= '0;
      pt_q <= '0;
    end else if (s1_fire) begin
      if (s1_last_col_q) begin
        rc_q <= '0;
        pl_q <= '0;
        pt_q <= '0;
      end else begin
        rc_q <= carry_all;
        pl_q <= pend_left_all;
        pt_q <= pend_this_all;
      end
    end
  end

  // end-of-row entry held until the write port is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_v_q <= 1'b0;
    end else if (s1_fire && s1_last_col_q) begin
      tail_v_q <= 1'b1;
    end else if (tail_ret) begin
      tail_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_col_q) begin
      tail_addr_q <= s1_x_q;
      tail_q      <= pend_left_all;
    end
  end

  // output register
  edd_pkg::pix_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_fire) begin
      out_v_q <= 1'b1;
    end else if (pix_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q.red_bit    <= bits[0];
      out_q.green_bit  <= bits[1];
      out_q.blue_bit   <= bits[2];
      out_q.frame_last <= s1_last_col_q && s1_last_row_q;
    end
  end

  assign pix_o.valid = out_v_q;
  assign pix_o.data  = out_q;

endmodule

// ----- rtl/edd_checker.sv -----
// ----------------------------------------------------------------------------
// edd_checker
// Port-level checks of the dither unit: output hold, occupancy and latency.
// ----------------------------------------------------------------------------
module edd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input edd_pkg::pix_out_t out_word_i
);

  logic       in_fire, out_fire;
  logic [1:0] cnt_q;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  // words accepted and not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_fire && !out_fire) begin
      cnt_q <= cnt_q + 2'd1;
    end else if (out_fire && !in_fire) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i))
    else $error("stalled output word changed");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != 2'd0)
    else $error("output word without an accepted input word");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("more than two words in flight");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> cnt_q == 2'd2)
    else $error("input stalled while the pipeline has room");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && cnt_q == 2'd0 |=> !out_valid_i ##1 out_valid_i)
    else $error("word through an empty pipeline not shown after two cycles");

endmodule

bind error_diffusion_dither_unit edd_checker u_edd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (pix_i.valid),
  .in_ready_i (pix_i.ready),
  .out_valid_i(pix_o.valid),
  .out_ready_i(pix_o.ready),
  .out_word_i (pix_o.data)
);
